FILE: rtl/pq_pkg.sv
package pq_pkg;

    // Palette geometry.
    localparam int PALETTE_SIZE = 4;
    localparam int STOCK_BITS   = 16;

    // Field widths fixed by the stream format.
    localparam int PIXEL_W     = 32;
    localparam int ENTRY_IDX_W = 2;
    localparam int DIST_W      = 10;
    localparam int CNT_W       = 3;
    localparam int BYTE_W      = 8;

    // Configuration port geometry.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int COLOR_LSB  = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PALETTE_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRINT_MODE    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_BASE    = 3'd2;

    // Input actions carried in s_tuser.
    localparam logic ACTION_CONVERT = 1'b0;
    localparam logic ACTION_RELOAD  = 1'b1;

    // Distance reported when no entry is eligible; also the exclusive limit.
    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 10'd765;

    // Result tdata layout, lowest bit first.
    localparam int M_TDATA_W   = 48;
    localparam int OUT_IDX_LSB = PIXEL_W;
    localparam int OUT_DST_LSB = PIXEL_W + ENTRY_IDX_W;
    localparam int OUT_PAD_W   = M_TDATA_W - PIXEL_W - ENTRY_IDX_W - DIST_W;

    typedef logic [PALETTE_SIZE-1:0][STOCK_BITS-1:0] stock_vec_t;

    typedef struct packed {
        logic [CNT_W-1:0]                        palette_count;
        logic                                    print_mode;
        logic [PALETTE_SIZE-1:0][PIXEL_W-1:0]    color;
        logic [PALETTE_SIZE-1:0][STOCK_BITS-1:0] init_stock;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0]     pixel_out;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic                   matched;
        logic [DIST_W-1:0]      best_distance;
        logic [PALETTE_SIZE-1:0] dec_en;
    } match_t;

    typedef struct packed {
        logic                    step;
        logic                    reload;
        logic [PALETTE_SIZE-1:0] dec_en;
    } stock_upd_t;

    function automatic logic [BYTE_W-1:0] abs_diff(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Manhattan distance over red, green and blue; alpha is ignored.
    function automatic logic [DIST_W-1:0] l1_dist(input logic [PIXEL_W-1:0] p,
                                                  input logic [PIXEL_W-1:0] c);
        logic [DIST_W-1:0] dr;
        logic [DIST_W-1:0] dg;
        logic [DIST_W-1:0] db;
        dr = DIST_W'(abs_diff(p[23:16], c[23:16]));
        dg = DIST_W'(abs_diff(p[15:8], c[15:8]));
        db = DIST_W'(abs_diff(p[7:0], c[7:0]));
        return dr + dg + db;
    endfunction

endpackage

FILE: rtl/palette_quantizer_with_stock_core.sv
// The input transaction is captured in the input registers, and its result in the output
// registers that drive m_tvalid; a stall on m_tready can hold it between the two.
// One item per cycle unless stalled; stock updates take effect for the next item.
// A reload transaction updates the stock counters and produces no result.
// The rate is set by the single distance and select stage between two registers.
// Reset (aresetn low, synchronous) clears the pipeline valids, all configuration
// registers and the stock counters.
module palette_quantizer_with_stock_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pq_pkg::PIXEL_W-1:0]        s_tdata,   // [31:0] pixel_in
    input  logic                              s_tuser,   // [0] action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pixel_out, [33:32] entry_index, [43:34] best_distance, [47:44] zero
    output logic [pq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                              m_tuser,   // [0] matched
    input  logic                              cfg_we,
    input  logic [pq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    pq_pkg::cfg_t       cfg;
    pq_pkg::stock_vec_t stock;
    pq_pkg::match_t     res;
    pq_pkg::stock_upd_t upd;

    logic                        in_valid_reg;
    logic                        in_action_reg;
    logic [pq_pkg::PIXEL_W-1:0]  in_pixel_reg;
    logic                        m_valid_reg;
    logic [pq_pkg::M_TDATA_W-1:0] m_data_reg;
    logic                        m_user_reg;
    logic                        out_ready;
    logic [pq_pkg::M_TDATA_W-1:0] m_data_next;

    pq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pq_stock_bank u_stock (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .upd     (upd),
        .stock   (stock)
    );

    pq_nearest u_nearest (
        .cfg   (cfg),
        .stock (stock),
        .pixel (in_pixel_reg),
        .res   (res)
    );

    // The whole pipe stalls only when a result waits and is not taken.
    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    assign upd.step   = in_valid_reg && out_ready;
    assign upd.reload = (in_action_reg == pq_pkg::ACTION_RELOAD);
    assign upd.dec_en = res.dec_en;

    assign m_data_next = {pq_pkg::OUT_PAD_W'(0), res.best_distance, res.entry_index,
                          res.pixel_out};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= in_valid_reg &&
                               (in_action_reg == pq_pkg::ACTION_CONVERT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_pixel_reg  <= s_tdata;
        end
        if (out_ready && in_valid_reg) begin
            m_data_reg <= m_data_next;
            m_user_reg <= res.matched;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/pq_cfg_regs.sv
module pq_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output pq_pkg::cfg_t                   cfg
);

    pq_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == pq_pkg::REG_PALETTE_COUNT) begin
                cfg_reg.palette_count <= cfg_wdata[pq_pkg::CNT_W-1:0];
            end
            if (cfg_addr == pq_pkg::REG_PRINT_MODE) begin
                cfg_reg.print_mode <= cfg_wdata[0];
            end
            for (int i = 0; i < pq_pkg::PALETTE_SIZE; i++) begin
                if (cfg_addr == pq_pkg::REG_ENTRY_BASE + pq_pkg::CFG_ADDR_W'(i)) begin
                    cfg_reg.color[i] <=
                        cfg_wdata[pq_pkg::COLOR_LSB +: pq_pkg::PIXEL_W];
                    cfg_reg.init_stock[i] <= cfg_wdata[pq_pkg::STOCK_BITS-1:0];
                end
            end
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/pq_stock_bank.sv
module pq_stock_bank (
    input  logic                aclk,
    input  logic                aresetn,
    input  pq_pkg::cfg_t        cfg,
    input  pq_pkg::stock_upd_t  upd,
    output pq_pkg::stock_vec_t  stock
);

    pq_pkg::stock_vec_t stock_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stock_reg <= '0;
        end else if (upd.step) begin
            for (int i = 0; i < pq_pkg::PALETTE_SIZE; i++) begin
                if (upd.reload) begin
                    stock_reg[i] <= cfg.init_stock[i];
                end else if (upd.dec_en[i]) begin
                    stock_reg[i] <= stock_reg[i] - 1'b1;
                end
            end
        end
    end

    assign stock = stock_reg;

endmodule

FILE: rtl/pq_nearest.sv
module pq_nearest (
    input  pq_pkg::cfg_t                cfg,
    input  pq_pkg::stock_vec_t          stock,
    input  logic [pq_pkg::PIXEL_W-1:0]  pixel,
    output pq_pkg::match_t              res
);

    localparam logic [pq_pkg::CNT_W-1:0] SIZE_CNT = pq_pkg::CNT_W'(pq_pkg::PALETTE_SIZE);

    logic [pq_pkg::CNT_W-1:0]  n_active;
    logic [pq_pkg::DIST_W-1:0] entry_dist [pq_pkg::PALETTE_SIZE];

    always_comb begin
        n_active = (cfg.palette_count > SIZE_CNT) ? SIZE_CNT : cfg.palette_count;
        for (int i = 0; i < pq_pkg::PALETTE_SIZE; i++) begin
            entry_dist[i] = pq_pkg::l1_dist(pixel, cfg.color[i]);
        end
    end

    // Strict less-than keeps the lowest index on a tie.
    always_comb begin
        res.best_distance = pq_pkg::NO_MATCH_DIST;
        res.pixel_out     = pixel;
        res.entry_index   = '0;
        res.matched       = 1'b0;
        for (int i = 0; i < pq_pkg::PALETTE_SIZE; i++) begin
            if ((pq_pkg::CNT_W'(i) < n_active) && (entry_dist[i] < res.best_distance) &&
                (stock[i] != '0)) begin
                res.best_distance = entry_dist[i];
                res.pixel_out     = cfg.color[i];
                res.entry_index   = pq_pkg::ENTRY_IDX_W'(i);
                res.matched       = 1'b1;
            end
        end
        // In print mode no match charges entry 0 if stocked and in use.
        for (int i = 0; i < pq_pkg::PALETTE_SIZE; i++) begin
            res.dec_en[i] = cfg.print_mode && (n_active != '0) &&
                            (res.entry_index == pq_pkg::ENTRY_IDX_W'(i)) &&
                            (stock[i] != '0);
        end
    end

endmodule

FILE: rtl/pq_checker.sv
module pq_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [pq_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                              m_tuser
);

    logic [pq_pkg::DIST_W-1:0]      out_dist;
    logic [pq_pkg::ENTRY_IDX_W-1:0] out_idx;

    assign out_dist = m_tdata[pq_pkg::OUT_DST_LSB +: pq_pkg::DIST_W];
    assign out_idx  = m_tdata[pq_pkg::OUT_IDX_LSB +: pq_pkg::ENTRY_IDX_W];

    // A result that is held back must not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A matched entry is strictly closer than the no-match limit.
    a_match_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_dist < pq_pkg::NO_MATCH_DIST)
        else $error("matched result with distance at or above limit");

    // An unmatched result reports entry zero at the limit distance.
    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> out_dist == pq_pkg::NO_MATCH_DIST && out_idx == '0)
        else $error("unmatched result with wrong index or distance");

endmodule

bind palette_quantizer_with_stock_core pq_checker u_pq_checker (.*);
